### hw/rtl/fkr_pkg.sv
`default_nettype none

package fkr_pkg;

  // Widths of the words on the two channels.
  localparam int unsigned ID_W   = 16;
  localparam int unsigned OCC_W  = 5;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned STAT_W = 2;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ = 2'd0,
    CMD_DEQ = 2'd1,
    CMD_REM = 2'd2,
    CMD_NOP = 2'd3
  } cmd_e;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic enq;
    logic rem;
  } cell_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/fkr_cmd_if.sv
`default_nettype none

interface fkr_cmd_if;
  import fkr_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [ID_W-1:0]  proc_id;

  modport source (output valid, output command, output proc_id, input ready);
  modport sink (input valid, input command, input proc_id, output ready);
endinterface

`default_nettype wire

### hw/rtl/fkr_res_if.sv
`default_nettype none

interface fkr_res_if;
  import fkr_pkg::*;

  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   out_id;
  logic [STAT_W-1:0] status;
  logic [OCC_W-1:0]  occupancy;
  logic              is_empty;

  modport source (output valid, output out_id, output status, output occupancy,
                  output is_empty, input ready);
  modport sink (input valid, input out_id, input status, input occupancy,
                input is_empty, output ready);
endinterface

`default_nettype wire

### hw/rtl/fkr_cell.sv
`default_nettype none

module fkr_cell #(
  parameter int unsigned ID_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire fkr_pkg::cell_ctl_t ctl_i,
  input  wire logic [ID_BITS-1:0] key_i,
  input  wire logic               prev_valid_i,
  input  wire logic               shift_i,
  input  wire logic [ID_BITS-1:0] next_id_i,
  input  wire logic               next_valid_i,
  output logic [ID_BITS-1:0]      id_o,
  output logic                    valid_o,
  output logic                    shift_o
);
  import fkr_pkg::*;

  logic [ID_BITS-1:0] id_q, id_d;
  logic               valid_q, valid_d;
  logic               match;
  logic               tail;

  // This cell holds the key, or it is the first free slot behind the tail.
  assign match   = valid_q && (id_q == key_i);
  assign tail    = !valid_q && prev_valid_i;
  // Once a cell is taken out, it and every cell behind it pull from the next.
  assign shift_o = shift_i || (ctl_i.rem && match);

  // Next contents of the cell.
  always_comb begin
    id_d    = id_q;
    valid_d = valid_q;
    if (shift_o) begin
      id_d    = next_id_i;
      valid_d = next_valid_i;
    end else if (ctl_i.enq && tail) begin
      id_d    = key_i;
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign id_o    = id_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

### hw/rtl/process_fifo_with_keyed_removal.sv
// The result word is registered: it appears in the cycle after its command word is accepted.
// Throughput: one command per cycle while results are taken; the result register
// frees in the cycle it is taken, so a new command is accepted in that same cycle.
// Each command settles combinationally: the removal hit ripples through the cell chain.
// Reset clears every valid mark, the fill count and the result valid flag.
`default_nettype none

module process_fifo_with_keyed_removal #(
  parameter int unsigned DEPTH   = 16,
  parameter int unsigned ID_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fkr_cmd_if.sink   cmd_i,
  fkr_res_if.source res_o
);
  import fkr_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_e               cmd;
  logic [ID_BITS-1:0] key;
  logic               accept;
  cell_ctl_t          ctl;

  logic [ID_BITS-1:0] cell_id    [DEPTH];
  logic [DEPTH-1:0]   cell_valid;
  logic [DEPTH:0]     shift;

  logic [CntW-1:0]    count_q, count_d;
  logic               full, empty, found;

  logic               res_valid_q;
  logic [ID_W-1:0]    out_id_q, out_id_d;
  status_e            status_q, status_d;
  logic [OCC_W-1:0]   occ_q;
  logic               empty_q;

  // Handshake: take a command whenever the result register is free or draining.
  assign cmd    = cmd_e'(cmd_i.command);
  assign key    = ID_BITS'(cmd_i.proc_id);
  assign accept = cmd_i.valid && cmd_i.ready;
  assign cmd_i.ready = !res_valid_q || res_o.ready;

  assign ctl.enq  = accept && (cmd == CMD_ENQ);
  assign ctl.rem  = accept && (cmd == CMD_REM);
  assign shift[0] = accept && (cmd == CMD_DEQ);

  // The chain of cells, head at cell zero.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ID_BITS-1:0] nxt_id;
    logic               nxt_valid;
    logic               prv_valid;

    if (i == DEPTH - 1) begin : g_last
      assign nxt_id    = cell_id[i];
      assign nxt_valid = 1'b0;
    end else begin : g_mid
      assign nxt_id    = cell_id[i+1];
      assign nxt_valid = cell_valid[i+1];
    end

    if (i == 0) begin : g_head
      assign prv_valid = 1'b1;
    end else begin : g_body
      assign prv_valid = cell_valid[i-1];
    end

    fkr_cell #(
      .ID_BITS(ID_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .key_i        (key),
      .prev_valid_i (prv_valid),
      .shift_i      (shift[i]),
      .next_id_i    (nxt_id),
      .next_valid_i (nxt_valid),
      .id_o         (cell_id[i]),
      .valid_o      (cell_valid[i]),
      .shift_o      (shift[i+1])
    );
  end

  assign full  = (count_q == CntW'(DEPTH));
  assign empty = (count_q == '0);
  assign found = shift[DEPTH];

  // Result word and next fill count.
  always_comb begin
    count_d  = count_q;
    out_id_d = '0;
    status_d = ST_OK;
    case (cmd)
      CMD_ENQ: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      CMD_DEQ: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          out_id_d = ID_W'(cell_id[0]);
          count_d  = count_q - CntW'(1);
        end
      end
      CMD_REM: begin
        if (found) begin
          out_id_d = ID_W'(key);
          count_d  = count_q - CntW'(1);
        end else begin
          status_d = ST_NOTFOUND;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_id_q <= out_id_d;
      status_q <= status_d;
      occ_q    <= OCC_W'(count_d);
      empty_q  <= (count_d == '0);
    end
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.out_id    = out_id_q;
  assign res_o.status    = status_q;
  assign res_o.occupancy = occ_q;
  assign res_o.is_empty  = empty_q;

  // The fill count never passes the depth.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("fill count exceeds depth");

  // Valid marks form a solid run from the head and agree with the fill count.
  a_valid_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_valid & (cell_valid + DEPTH'(1))) == '0) &&
    ($countones(cell_valid) == int'(count_q)))
    else $error("valid marks do not match the fill count");

  // An enqueue that finds room grows the queue by one.
  a_enq_grow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (cmd == CMD_ENQ) && !full |=> count_q == $past(count_q) + CntW'(1))
    else $error("enqueue did not add an entry");

endmodule

`default_nettype wire
